// ----- rtl/vp9_rtp_frame_reassembler_assert.svh -----
// ----------------------------------------------------------------------------
// VP9 RTP frame reassembler assertion macros
// Concurrent checks clocked on the rising edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef VP9_RTP_FRAME_REASSEMBLER_ASSERT_SVH
`define VP9_RTP_FRAME_REASSEMBLER_ASSERT_SVH

// condition holds at every edge
`define VP9RF_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent on the next edge
`define VP9RF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/vp9rf_pkg.sv -----
// ----------------------------------------------------------------------------
// VP9 RTP frame reassembler package
// Store sizing, descriptor bit masks, codes and channel payload types.
// ----------------------------------------------------------------------------
package vp9rf_pkg;

   localparam int FRAME_BYTES = 65536;
   localparam int ADDR_W      = $clog2(FRAME_BYTES);
   localparam int LEN_W       = $clog2(FRAME_BYTES + 1);

   localparam logic [15:0] TIMEOUT_RESET = 16'd500;

   localparam logic [7:0] DESC_START_BIT = 8'h08;
   localparam logic [7:0] DESC_END_BIT   = 8'h04;
   localparam logic [7:0] PID_EXT_BIT    = 8'h80;
   localparam logic [7:0] PID_LOW_MASK   = 8'h7F;

   typedef enum logic [1:0] {
      KIND_STATUS     = 2'd0,
      KIND_FRAME_BYTE = 2'd1,
      KIND_EMPTY      = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OUT_STARTED   = 2'd0,
      OUT_APPENDED  = 2'd1,
      OUT_IGNORED   = 2'd2,
      OUT_MALFORMED = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      PH_DESC    = 2'd0,
      PH_PID_HI  = 2'd1,
      PH_PID_LO  = 2'd2,
      PH_PAYLOAD = 2'd3
   } phase_type;

   typedef struct packed {
      logic        action;
      logic [7:0]  body_byte;
      logic        first_of_packet;
      logic        last_of_packet;
      logic [31:0] rtp_timestamp;
      logic        rtp_marker;
      logic [31:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [7:0]  frame_byte;
      logic        last_of_frame;
      logic        frame_complete;
      logic [16:0] frame_length;
      outcome_type packet_outcome;
      logic        timeout_flushed;
      logic        picture_id_mismatch;
      logic        overflow;
   } rsp_payload_type;

endpackage

// ----- rtl/vp9rf_channels.sv -----
// ----------------------------------------------------------------------------
// VP9 RTP frame reassembler channels
// Valid/ready request and response channels with source and sink modports.
// ----------------------------------------------------------------------------
interface vp9rf_req_if;
   import vp9rf_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface vp9rf_rsp_if;
   import vp9rf_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/vp9_rtp_frame_reassembler.sv -----
// ----------------------------------------------------------------------------
// VP9 RTP frame reassembler
// Parses the VP9 payload descriptor of RTP bodies, assembles one frame in a
// byte store and drains it on read requests.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request per cycle: a body byte (action 0) with its
//   packet's timestamp, marker and time, or a read of the next frame byte
//   (action 1). rsp_chan returns a packet status on the last byte of each
//   packet, a frame byte or an empty indication on each read, and nothing
//   for other body bytes. csr_wr_en/csr_wr_data set the flush timeout in ms.
//   Pipeline: two register stages; a response enters the inner stage at
//   acceptance and moves on to the output stage once that is free or taken.
//   The inner stage holds the registered read.
//   Throughput: one request per cycle unless stalled as below, set by the
//   state update and the one write or read port of the frame store.
//   Reset: the frame is empty, the timeout is 500 ms, no response pending.
//   The frame store needs no clearing pass; reset takes effect at once.
//   Stall: while rsp_chan is held, requests that give no response keep
//   flowing as long as the inner stage is empty; one that gives a response
//   fills it, and req_chan.ready then drops until the held response is taken.
// ----------------------------------------------------------------------------
`include "vp9_rtp_frame_reassembler_assert.svh"

module vp9_rtp_frame_reassembler (
   input  logic               clock,
   input  logic               reset,
   vp9rf_req_if.sink          req_chan,
   vp9rf_rsp_if.source        rsp_chan,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);
   import vp9rf_pkg::*;

   logic [7:0] frame_mem [FRAME_BYTES];

   logic [LEN_W-1:0]  stored_ff,   stored_in;
   logic [LEN_W-1:0]  rp_ff,       rp_in;
   logic [31:0]       stamp_ff,    stamp_in;
   logic              end_seen_ff, end_seen_in;
   logic [14:0]       fpid_ff,     fpid_in;
   logic [15:0]       frag_ff,     frag_in;
   logic [31:0]       last_arr_ff, last_arr_in;
   phase_type         phase_ff,    phase_in;
   logic [7:0]        desc_ff,     desc_in;
   logic [14:0]       ppid_ff,     ppid_in;
   outcome_type       disp_ff,     disp_in;
   logic              flush_ff,    flush_in;
   logic              ovf_ff,      ovf_in;
   logic [15:0]       timeout_ff,  timeout_in;

   logic              s1_valid_ff, s1_valid_in;
   rsp_payload_type   s1_ff,       s1_in;
   logic [7:0]        rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff,      rsp_in;

   logic              advance;
   logic              accept;
   logic              pkt_start;
   phase_type         phase_cur;
   logic              do_decide;
   logic              ends;
   logic              mem_we;
   logic              mem_re;
   logic              res_valid;
   rsp_payload_type   res;
   req_payload_type   p;

   assign p         = req_chan.payload;
   assign advance   = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance || !s1_valid_ff;
   assign accept    = req_chan.valid && req_chan.ready;
   assign pkt_start = p.first_of_packet || (phase_ff == PH_DESC);
   assign phase_cur = pkt_start ? PH_DESC : phase_ff;
   assign timeout_in = csr_wr_en ? csr_wr_data : timeout_ff;

   always_comb begin
      phase_in = phase_ff;
      if (accept && !p.action) begin
         case (phase_cur)
            PH_DESC: begin
               if ((p.body_byte & PID_EXT_BIT) != 8'h00) begin
                  phase_in = p.last_of_packet ? PH_DESC : PH_PID_HI;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PID_HI: begin
               if ((p.body_byte & PID_EXT_BIT) != 8'h00) begin
                  phase_in = p.last_of_packet ? PH_DESC : PH_PID_LO;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            default: phase_in = PH_PAYLOAD;
         endcase
         if (p.last_of_packet) begin
            phase_in = PH_DESC;
         end
      end
   end

   always_comb begin
      stored_in   = stored_ff;
      rp_in       = rp_ff;
      stamp_in    = stamp_ff;
      end_seen_in = end_seen_ff;
      fpid_in     = fpid_ff;
      frag_in     = frag_ff;
      last_arr_in = last_arr_ff;
      desc_in     = desc_ff;
      ppid_in     = ppid_ff;
      disp_in     = disp_ff;
      flush_in    = flush_ff;
      ovf_in      = ovf_ff;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      do_decide   = 1'b0;
      ends        = 1'b0;
      res_valid   = 1'b0;
      res         = '0;
      if (accept) begin
         if (p.action) begin
            res_valid = 1'b1;
            if (stored_ff == '0 || rp_ff >= stored_ff) begin
               res.result_kind = KIND_EMPTY;
            end else begin
               res.result_kind = KIND_FRAME_BYTE;
               mem_re = 1'b1;
               rp_in  = rp_ff + LEN_W'(1);
               if (rp_in >= stored_ff) begin
                  res.last_of_frame = 1'b1;
                  stored_in   = '0;
                  rp_in       = '0;
                  end_seen_in = 1'b0;
                  frag_in     = '0;
                  stamp_in    = '1;
                  last_arr_in = '0;
               end
            end
         end else begin
            if (pkt_start) begin
               flush_in = 1'b0;
               ovf_in   = 1'b0;
               ppid_in  = '0;
               disp_in  = OUT_STARTED;
               if (stored_ff != '0 && (p.now_ms - last_arr_ff) > {16'h0000, timeout_ff}) begin
                  stored_in   = '0;
                  rp_in       = '0;
                  end_seen_in = 1'b0;
                  frag_in     = '0;
                  stamp_in    = '1;
                  flush_in    = 1'b1;
               end
            end
            case (phase_cur)
               PH_DESC: begin
                  desc_in = p.body_byte;
                  if ((p.body_byte & PID_EXT_BIT) != 8'h00) begin
                     if (p.last_of_packet) begin
                        disp_in = OUT_MALFORMED;
                     end
                  end else begin
                     do_decide = 1'b1;
                  end
               end
               PH_PID_HI: begin
                  if ((p.body_byte & PID_EXT_BIT) != 8'h00) begin
                     ppid_in = {p.body_byte[6:0], 8'h00};
                     if (p.last_of_packet) begin
                        disp_in = OUT_MALFORMED;
                     end
                  end else begin
                     ppid_in = {8'h00, p.body_byte[6:0]};
                     do_decide = 1'b1;
                  end
               end
               PH_PID_LO: begin
                  ppid_in   = ppid_ff | {7'h00, p.body_byte};
                  do_decide = 1'b1;
               end
               default: begin
                  if (disp_ff inside {OUT_STARTED, OUT_APPENDED}) begin
                     if (stored_ff < LEN_W'(FRAME_BYTES)) begin
                        mem_we    = 1'b1;
                        stored_in = stored_ff + LEN_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
               end
            endcase
            if (do_decide) begin
               ends = ((desc_in & DESC_END_BIT) != 8'h00) || p.rtp_marker;
               if ((desc_in & DESC_START_BIT) != 8'h00) begin
                  stored_in   = '0;
                  rp_in       = '0;
                  stamp_in    = p.rtp_timestamp;
                  end_seen_in = ends;
                  fpid_in     = ppid_in;
                  frag_in     = 16'd1;
                  last_arr_in = p.now_ms;
                  disp_in     = OUT_STARTED;
               end else if (p.rtp_timestamp == stamp_in) begin
                  if (ends) begin
                     end_seen_in = 1'b1;
                  end
                  frag_in     = frag_in + 16'd1;
                  last_arr_in = p.now_ms;
                  disp_in     = OUT_APPENDED;
               end else begin
                  disp_in = OUT_IGNORED;
               end
            end
            if (p.last_of_packet) begin
               res_valid               = 1'b1;
               res.result_kind         = KIND_STATUS;
               res.frame_complete      = (stored_in != '0) && end_seen_in;
               res.frame_length        = 17'(stored_in);
               res.packet_outcome      = disp_in;
               res.timeout_flushed     = flush_in;
               res.overflow            = ovf_in;
               res.picture_id_mismatch = (disp_in == OUT_APPENDED) && (ppid_in != '0) &&
                                         (fpid_in != '0) && (ppid_in != fpid_in);
            end
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (accept) begin
         s1_valid_in = res_valid;
         s1_in       = res;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
         rsp_in       = s1_ff;
         rsp_in.frame_byte = (s1_ff.result_kind == KIND_FRAME_BYTE) ? rd_data_ff : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[stored_ff[ADDR_W-1:0]] <= p.body_byte;
      end
      if (mem_re) begin
         rd_data_ff <= frame_mem[rp_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff    <= '0;
         rp_ff        <= '0;
         stamp_ff     <= '1;
         end_seen_ff  <= 1'b0;
         fpid_ff      <= '0;
         frag_ff      <= '0;
         last_arr_ff  <= '0;
         phase_ff     <= PH_DESC;
         desc_ff      <= '0;
         ppid_ff      <= '0;
         disp_ff      <= OUT_STARTED;
         flush_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stored_ff    <= stored_in;
         rp_ff        <= rp_in;
         stamp_ff     <= stamp_in;
         end_seen_ff  <= end_seen_in;
         fpid_ff      <= fpid_in;
         frag_ff      <= frag_in;
         last_arr_ff  <= last_arr_in;
         phase_ff     <= phase_in;
         desc_ff      <= desc_in;
         ppid_ff      <= ppid_in;
         disp_ff      <= disp_in;
         flush_ff     <= flush_in;
         ovf_ff       <= ovf_in;
         timeout_ff   <= timeout_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   `VP9RF_ASSERT_ALWAYS(a_len_bound, clock, reset, stored_ff <= LEN_W'(FRAME_BYTES), "frame length beyond store size")
   `VP9RF_ASSERT_ALWAYS(a_rp_bound, clock, reset, rp_ff <= stored_ff, "read pointer beyond frame length")
   `VP9RF_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !advance, s1_valid_ff && $stable(s1_ff), "inner stage lost a request under stall")
   `VP9RF_ASSERT_NEXT(a_drain_clear, clock, reset, accept && res_valid && res.last_of_frame, stored_ff == '0 && rp_ff == '0 && stamp_ff == '1, "frame not cleared after drain")

endmodule
